/* design/altbl_pkg.sv */
package altbl_pkg;

  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CAP_W     = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [3:0] MODE_APPEND   = 4'd0;
  localparam logic [3:0] MODE_PREPEND  = 4'd1;
  localparam logic [3:0] MODE_INSERT   = 4'd2;
  localparam logic [3:0] MODE_SORTED   = 4'd3;
  localparam logic [3:0] MODE_POP_LAST = 4'd4;
  localparam logic [3:0] MODE_POP_FRST = 4'd5;
  localparam logic [3:0] MODE_POP_AT   = 4'd6;
  localparam logic [3:0] MODE_REMOVE   = 4'd7;
  localparam logic [3:0] MODE_CONTAINS = 4'd8;
  localparam logic [3:0] MODE_FIND     = 4'd9;
  localparam logic [3:0] MODE_READ     = 4'd10;
  localparam logic [3:0] MODE_WRITE    = 4'd11;
  localparam logic [3:0] MODE_CLEAR    = 4'd12;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_EMPTY    = 3'd2;
  localparam logic [2:0] STAT_BADPOS   = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] value;
    logic [8:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic [8:0]         result_index;
    logic               found;
    logic [8:0]         entry_count;
  } out_word_t;

endpackage

/* design/array_list_table_engine_core.sv */
// channel  | ports                          | role
// ---------+--------------------------------+---------------------------------
// in       | in_valid, in_stall, in_word    | one operation word per item
// out      | out_valid, out_stall, out_word | one result word per item
// cfg      | cfg_we, cfg_wdata              | capacity register, write only
//
// after acceptance a word is decoded; write, clear, unused modes and errors then go
// straight to the response step. inserts pass through the shift-up step, and
// removals and reads through the shift-down step; sorted insert, remove match and
// searches first scan the list from the front. the next word is accepted only
// after the response step has loaded the output register. the single read and
// single write port of the entry memory move one entry per cycle.
// reset clears the count and sets capacity to 256; the memory is not cleared.
// in_stall stays high from acceptance until the result enters the output
// register, which holds its word while out_stall is high.
module array_list_table_engine_core
  import altbl_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned KW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_SHUP = 6'b001000,
    ST_SHDN = 6'b010000,
    ST_RESP = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CAP_W-1:0]              cap_r;
  logic [3:0]                    mode_r, mode_nxt;
  logic signed [DATA_WIDTH-1:0]  val_r, val_nxt;
  logic [8:0]                    pos_r, pos_nxt;
  logic [CW-1:0]                 at_r, at_nxt;
  logic [CW-1:0]                 lim_r, lim_nxt;
  logic [CW-1:0]                 ptr_r, ptr_nxt;
  logic [CW-1:0]                 tag_r, tag_nxt;
  logic                          pend_r, pend_nxt;
  logic [2:0]                    status_r, status_nxt;
  logic signed [DATA_WIDTH-1:0]  rv_r, rv_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          found_r, found_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_word_t                     out_word_r, out_word_nxt;

  logic [DATA_WIDTH-1:0]         entry_mem [DEPTH];
  logic signed [DATA_WIDTH-1:0]  rd_data_r;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic [DATA_WIDTH-1:0]         mem_wd;
  logic [AW-1:0]                 mem_ra;

  logic [63:0]                   vin_ext;
  logic signed [63:0]            rv_ext;
  logic [KW-1:0]                 count_k;
  logic [KW-1:0]                 cap_k;
  logic [KW-1:0]                 pos_k;
  logic [KW-1:0]                 idx_k;
  logic                          full;
  logic                          empty;
  logic                          out_free;
  logic                          hit_now;

  assign vin_ext  = {32'd0, in_word.value};
  assign count_k  = KW'(count_r);
  assign cap_k    = (KW'(cap_r) > KW'(DEPTH)) ? KW'(DEPTH) : KW'(cap_r);
  assign pos_k    = KW'(pos_r);
  assign idx_k    = KW'(idx_r);
  assign full     = count_k >= cap_k;
  assign empty    = count_r == '0;
  assign out_free = !out_valid_r || !out_stall;
  assign rv_ext   = 64'(rv_r);
  assign hit_now  = pend_r && ((mode_r == MODE_SORTED) ? (rd_data_r >= val_r)
                                                       : (rd_data_r == val_r));

  always_comb begin
    logic [CW-1:0] sidx;
    logic          shit;
    logic          sdone;

    state_nxt     = state_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    at_nxt        = at_r;
    lim_nxt       = lim_r;
    ptr_nxt       = ptr_r;
    tag_nxt       = tag_r;
    pend_nxt      = pend_r;
    status_nxt    = status_r;
    rv_nxt        = rv_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_wa        = at_r[AW-1:0];
    mem_wd        = val_r;
    mem_ra        = ptr_r[AW-1:0];
    sidx          = count_r;
    shit          = 1'b0;
    sdone         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_word.mode;
          val_nxt    = vin_ext[DATA_WIDTH-1:0];
          pos_nxt    = in_word.position;
          status_nxt = STAT_OK;
          rv_nxt     = '0;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_RESP;
        ptr_nxt   = '0;
        unique case (mode_r)
          MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
            if (full) begin
              status_nxt = STAT_FULL;
            end else if (mode_r == MODE_INSERT && pos_k > count_k) begin
              status_nxt = STAT_BADPOS;
            end else begin
              at_nxt    = (mode_r == MODE_APPEND)  ? count_r :
                          (mode_r == MODE_PREPEND) ? '0 : pos_k[CW-1:0];
              ptr_nxt   = count_r;
              state_nxt = ST_SHUP;
            end
          end
          MODE_SORTED: begin
            if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          MODE_POP_LAST, MODE_POP_FRST, MODE_POP_AT: begin
            if (empty) begin
              status_nxt = STAT_EMPTY;
            end else if (mode_r == MODE_POP_AT && pos_k >= count_k) begin
              status_nxt = STAT_BADPOS;
            end else begin
              at_nxt    = (mode_r == MODE_POP_LAST) ? count_r - CW'(1) :
                          (mode_r == MODE_POP_FRST) ? '0 : pos_k[CW-1:0];
              ptr_nxt   = at_nxt;
              lim_nxt   = count_r;
              state_nxt = ST_SHDN;
            end
          end
          MODE_REMOVE: begin
            if (empty) begin
              status_nxt = STAT_EMPTY;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          MODE_CONTAINS, MODE_FIND: begin
            state_nxt = ST_SCAN;
          end
          MODE_READ: begin
            if (pos_k >= count_k) begin
              status_nxt = STAT_BADPOS;
            end else begin
              at_nxt    = pos_k[CW-1:0];
              ptr_nxt   = pos_k[CW-1:0];
              lim_nxt   = pos_k[CW-1:0] + CW'(1);
              state_nxt = ST_SHDN;
            end
          end
          MODE_WRITE: begin
            if (pos_k >= count_k) begin
              status_nxt = STAT_BADPOS;
            end else begin
              mem_we = 1'b1;
              mem_wa = pos_k[AW-1:0];
            end
          end
          MODE_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        pend_nxt = 1'b0;
        if (hit_now) begin
          sdone = 1'b1;
          shit  = 1'b1;
          sidx  = tag_r;
        end else if (ptr_r < count_r) begin
          mem_ra   = ptr_r[AW-1:0];
          tag_nxt  = ptr_r;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + CW'(1);
        end else if (!pend_r) begin
          sdone = 1'b1;
        end
        if (sdone) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_RESP;
          unique case (mode_r)
            MODE_SORTED: begin
              at_nxt    = sidx;
              ptr_nxt   = count_r;
              state_nxt = ST_SHUP;
            end
            MODE_REMOVE: begin
              if (shit) begin
                idx_nxt   = sidx;
                at_nxt    = sidx;
                ptr_nxt   = sidx;
                lim_nxt   = count_r;
                state_nxt = ST_SHDN;
              end else begin
                status_nxt = STAT_NOTFOUND;
              end
            end
            MODE_FIND: begin
              idx_nxt   = sidx;
              found_nxt = shit;
            end
            default: begin
              found_nxt = shit;
            end
          endcase
        end
      end

      ST_SHUP: begin
        mem_ra = ptr_r[AW-1:0] - AW'(1);
        if (pend_r) begin
          mem_we   = 1'b1;
          mem_wa   = tag_r[AW-1:0];
          mem_wd   = rd_data_r;
          pend_nxt = 1'b0;
        end
        if (ptr_r > at_r) begin
          tag_nxt  = ptr_r;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r - CW'(1);
        end else if (!pend_r) begin
          mem_we    = 1'b1;
          mem_wa    = at_r[AW-1:0];
          mem_wd    = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_RESP;
        end
      end

      ST_SHDN: begin
        mem_ra = ptr_r[AW-1:0];
        if (pend_r) begin
          pend_nxt = 1'b0;
          if (tag_r == at_r) begin
            rv_nxt = rd_data_r;
          end else begin
            mem_we = 1'b1;
            mem_wa = tag_r[AW-1:0] - AW'(1);
            mem_wd = rd_data_r;
          end
        end
        if (ptr_r < lim_r) begin
          tag_nxt  = ptr_r;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + CW'(1);
        end else if (!pend_r) begin
          if (mode_r != MODE_READ) begin
            count_nxt = count_r - CW'(1);
          end
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.status       = status_r;
          out_word_nxt.result_value = rv_ext[31:0];
          out_word_nxt.result_index = idx_k[8:0];
          out_word_nxt.found        = found_r;
          out_word_nxt.entry_count  = count_k[8:0];
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= entry_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    val_r      <= val_nxt;
    pos_r      <= pos_nxt;
    at_r       <= at_nxt;
    lim_r      <= lim_nxt;
    ptr_r      <= ptr_nxt;
    tag_r      <= tag_nxt;
    status_r   <= status_nxt;
    rv_r       <= rv_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_k <= KW'(DEPTH))
    else $error("entry count above depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_EXEC)
    else $error("accepted word not decoded");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result word without response step");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(state_r == ST_EXEC || state_r == ST_SHUP ||
                                state_r == ST_SHDN))
    else $error("count changed outside an operation");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_RESP) |-> !pend_r)
    else $error("memory read left pending");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import altbl_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned MAX_SHOWN  = 10;

  localparam logic [3:0] MODE_SPARE_LO = 4'd13;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;

  localparam logic signed [31:0] VALUE_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VALUE_MIN = 32'sh80000000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // list state as seen through accepted words
  logic signed [31:0] list_mem [LIST_DEPTH];
  int unsigned        list_len = 0;
  int unsigned        list_cap = 32'(CAP_RESET);
  out_word_t          pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_len        = 0;
  bit          steady_sender  = 1'b0;
  logic [8:0]  stall_tick     = '0;

  array_list_table_engine_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_word_t apply_list_op(input in_word_t w);
    out_word_t          r;
    logic signed [31:0] v;
    int unsigned        cap_now, at, k, hit_at;
    bit                 is_full, is_empty;
    r        = '0;
    v        = w.value;
    cap_now  = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
    is_full  = list_len >= cap_now;
    is_empty = list_len == 0;
    hit_at   = 0;
    while (hit_at < list_len && list_mem[hit_at] !== v) hit_at++;
    r.status = STAT_OK;
    at       = 0;
    case (w.mode)
      MODE_APPEND, MODE_PREPEND, MODE_INSERT, MODE_SORTED: begin
        if (is_full) begin
          r.status = STAT_FULL;
        end else if (w.mode == MODE_INSERT && w.position > list_len) begin
          r.status = STAT_BADPOS;
        end else begin
          if (w.mode == MODE_APPEND) at = list_len;
          else if (w.mode == MODE_INSERT) at = 32'(w.position);
          else if (w.mode == MODE_SORTED) begin
            while (at < list_len && list_mem[at] < v) at++;
          end
          for (k = list_len; k > at; k--) list_mem[k] = list_mem[k-1];
          list_mem[at] = v;
          list_len++;
        end
      end
      MODE_POP_LAST, MODE_POP_FRST, MODE_POP_AT, MODE_REMOVE: begin
        if (w.mode == MODE_POP_LAST) at = list_len - 1;
        else if (w.mode == MODE_POP_AT) at = 32'(w.position);
        else if (w.mode == MODE_REMOVE) at = hit_at;
        if (is_empty) begin
          r.status = STAT_EMPTY;
        end else if (w.mode == MODE_POP_AT && at >= list_len) begin
          r.status = STAT_BADPOS;
        end else if (w.mode == MODE_REMOVE && at >= list_len) begin
          r.status = STAT_NOTFOUND;
        end else begin
          r.result_value = list_mem[at];
          if (w.mode == MODE_REMOVE) r.result_index = 9'(at);
          for (k = at; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      MODE_CONTAINS, MODE_FIND: begin
        r.found = hit_at < list_len;
        if (w.mode == MODE_FIND) r.result_index = 9'(hit_at);
      end
      MODE_READ: begin
        if (w.position >= list_len) r.status = STAT_BADPOS;
        else r.result_value = list_mem[w.position];
      end
      MODE_WRITE: begin
        if (w.position >= list_len) r.status = STAT_BADPOS;
        else list_mem[w.position] = v;
      end
      MODE_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = 9'(list_len);
    return r;
  endfunction

  task automatic send_op(input logic [3:0] mode, input logic signed [31:0] value,
                         input logic [8:0] position);
    in_word_t w;
    w.mode     = mode;
    w.value    = value;
    w.position = position;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pending_results = {pending_results, apply_list_op(w)};
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len    = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap_len > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we   <= 1'b0;
    list_cap = 32'(cap);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = (list_len != 0) ? list_mem[$urandom_range(0, list_len - 1)] : $urandom;
      4, 5:       v = $signed($urandom_range(0, 15)) - 8;
      6:          v = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random_op();
    logic [3:0]  mode;
    logic [8:0]  where;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 14) mode = MODE_APPEND;
    else if (roll < 22) mode = MODE_PREPEND;
    else if (roll < 32) mode = MODE_INSERT;
    else if (roll < 42) mode = MODE_SORTED;
    else if (roll < 48) mode = MODE_POP_LAST;
    else if (roll < 53) mode = MODE_POP_FRST;
    else if (roll < 60) mode = MODE_POP_AT;
    else if (roll < 67) mode = MODE_REMOVE;
    else if (roll < 72) mode = MODE_CONTAINS;
    else if (roll < 78) mode = MODE_FIND;
    else if (roll < 85) mode = MODE_READ;
    else if (roll < 92) mode = MODE_WRITE;
    else if (roll < 94) mode = MODE_CLEAR;
    else if (roll < 97) mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    else mode = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: where = 9'($urandom_range(0, list_len));
      7:                   where = 9'(list_len + 1);
      default:             where = 9'($urandom_range(0, 511));
    endcase
    send_op(mode, pick_value(), where);
  endtask

  task automatic test_directed();
    // empty list
    send_op(MODE_POP_LAST, 32'sd0, 9'd0);
    send_op(MODE_POP_FRST, 32'sd0, 9'd0);
    send_op(MODE_POP_AT, 32'sd0, 9'd0);
    send_op(MODE_REMOVE, 32'sd5, 9'd0);
    send_op(MODE_CONTAINS, 32'sd0, 9'd0);
    send_op(MODE_FIND, 32'sd0, 9'd0);
    send_op(MODE_READ, 32'sd0, 9'd0);
    send_op(MODE_WRITE, 32'sd1, 9'd0);
    // value extremes and positions
    send_op(MODE_APPEND, VALUE_MAX, 9'd0);
    send_op(MODE_PREPEND, VALUE_MIN, 9'd0);
    send_op(MODE_INSERT, 32'sd0, 9'd1);
    send_op(MODE_INSERT, 32'sd9, 9'd4);
    send_op(MODE_INSERT, 32'sd9, 9'h1FF);
    send_op(MODE_SORTED, -32'sd1, 9'd0);
    send_op(MODE_SORTED, VALUE_MAX, 9'd0);
    send_op(MODE_CONTAINS, 32'sd0, 9'd0);
    send_op(MODE_FIND, 32'sh12345678, 9'd0);
    send_op(MODE_READ, 32'sd0, 9'd3);
    send_op(MODE_READ, 32'sd0, 9'd5);
    send_op(MODE_WRITE, -32'sd1, 9'd2);
    send_op(MODE_REMOVE, -32'sd1, 9'd0);
    send_op(MODE_REMOVE, 32'sd77, 9'd0);
    send_op(MODE_POP_AT, 32'sd0, 9'd1);
    send_op(MODE_POP_AT, 32'sd0, 9'h100);
    send_op(MODE_POP_FRST, 32'sd0, 9'd0);
    send_op(MODE_POP_LAST, 32'sd0, 9'd0);
    send_op(MODE_SPARE_LO, VALUE_MAX, 9'h1FF);
    send_op(MODE_SPARE_HI, VALUE_MIN, 9'd0);
    send_op(MODE_CLEAR, 32'sd0, 9'd0);
  endtask

  task automatic test_capacity_limits();
    set_capacity(9'd1);
    send_op(MODE_APPEND, 32'sd3, 9'd0);
    send_op(MODE_APPEND, 32'sd4, 9'd0);
    send_op(MODE_INSERT, 32'sd4, 9'd5);
    send_op(MODE_SORTED, 32'sd4, 9'd0);
    send_op(MODE_PREPEND, 32'sd4, 9'd0);
    send_op(MODE_POP_LAST, 32'sd0, 9'd0);
    // zero capacity refuses every insert
    set_capacity(9'd0);
    send_op(MODE_APPEND, 32'sd1, 9'd0);
    send_op(MODE_PREPEND, 32'sd1, 9'd0);
    send_op(MODE_POP_LAST, 32'sd0, 9'd0);
    // capacity lowered below the count
    set_capacity(CAP_RESET);
    repeat (4) send_op(MODE_APPEND, $urandom, 9'd0);
    set_capacity(9'd2);
    send_op(MODE_APPEND, 32'sd1, 9'd0);
    send_op(MODE_POP_FRST, 32'sd0, 9'd0);
    send_op(MODE_CLEAR, 32'sd0, 9'd0);
    // oversized capacity acts as the full depth
    set_capacity(9'h1FF);
    repeat (LIST_DEPTH) send_op(MODE_APPEND, $urandom, 9'($urandom_range(0, 511)));
    send_op(MODE_APPEND, 32'sd1, 9'd0);
    send_op(MODE_SORTED, 32'sd1, 9'd0);
    send_op(MODE_INSERT, 32'sd1, 9'd0);
    send_op(MODE_FIND, list_mem[LIST_DEPTH-1], 9'd0);
    send_op(MODE_READ, 32'sd0, 9'd255);
    send_op(MODE_WRITE, VALUE_MIN, 9'd255);
    send_op(MODE_REMOVE, VALUE_MIN, 9'd0);
    send_op(MODE_POP_FRST, 32'sd0, 9'd0);
    send_op(MODE_INSERT, VALUE_MAX, 9'd0);
    send_op(MODE_SORTED, VALUE_MAX, 9'd0);
    send_op(MODE_POP_AT, 32'sd0, 9'd0);
    send_op(MODE_CLEAR, 32'sd0, 9'd0);
  endtask

  task automatic test_random_ops();
    logic [CAP_W-1:0] cap;
    int unsigned      span;
    for (int phase = 0; phase < 6; phase++) begin
      span = 40;
      case (phase)
        0:       cap = CAP_RESET;
        1:       cap = CAP_W'($urandom_range(1, 12));
        2:       cap = 9'h1FF;
        3: begin
          cap  = '0;
          span = 20;
        end
        4:       cap = CAP_W'($urandom_range(13, 300));
        default: cap = CAP_RESET;
      endcase
      steady_sender = (phase == 0 || phase == 4);
      set_capacity(cap);
      repeat (span) send_random_op();
    end
    steady_sender = 1'b0;
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 9'd1;
    case (stall_tick[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= 1'($urandom_range(0, 1));
      2'd2:    out_stall <= (stall_tick[2:0] < 3'd5);
      default: out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (mismatch_count < MAX_SHOWN)
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_field("unexpected word, entry_count", '0, 32'(out_word.entry_count));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_word.status !== want.status)
          report_field("status", 32'(want.status), 32'(out_word.status));
        if (out_word.result_value !== want.result_value)
          report_field("result_value", want.result_value, out_word.result_value);
        if (out_word.result_index !== want.result_index)
          report_field("result_index", 32'(want.result_index),
                       32'(out_word.result_index));
        if (out_word.found !== want.found)
          report_field("found", 32'(want.found), 32'(out_word.found));
        if (out_word.entry_count !== want.entry_count)
          report_field("entry_count", 32'(want.entry_count),
                       32'(out_word.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity_limits();
    test_random_ops();
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
